[hdl/eqgd_pkg.sv]
`timescale 1ns / 1ps
package eqgd_pkg;

	localparam int LAT_W    = 28;
	localparam int LON_W    = 29;
	localparam int RADIUS_W = 24;
	localparam int DIST_W   = 26;
	localparam int PADDR_W  = 3;

	localparam longint unsigned DEG_SCALE = 64'd1000000;

	localparam logic [29:0] FULL_TURN    = 30'(720 * DEG_SCALE);
	localparam logic [29:0] HALF_TURN    = 30'(360 * DEG_SCALE);
	localparam logic [29:0] QUARTER_TURN = 30'(180 * DEG_SCALE);

	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [29:0] PI_Q28  = 30'd843314856;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
	localparam logic [DIST_W-1:0]   DIST_MAX     = 26'h3ff_ffff;

	// half turn is 2^9 times the odd part, full turn 2^10 times
	localparam int HALF_SH = 9;
	localparam int FULL_SH = 10;
	localparam longint unsigned TURN_ODD = (720 * DEG_SCALE) >> FULL_SH;

	// floor(n / TURN_ODD) for n below 2^51 as (n * TURN_RECIP) >> RECIP_SH
	localparam int RECIP_SH = 71;
	localparam logic [51:0] TURN_RECIP =
		52'(((128'd1 << RECIP_SH) + 128'(TURN_ODD) - 128'd1) / 128'(TURN_ODD));

	localparam int SQ_W = 32;

	localparam int HORNER_N = 6;
	localparam int NSTG = 4 + 2 + 1 + 3 * HORNER_N + 3 + SQ_W + 1 + 2 + 2 + 2 + 1;

	// exact reciprocals for 32-bit dividends: ceil(2^sh / k)
	localparam int unsigned HORNER_SH [HORNER_N] = '{40, 39, 38, 37, 36, 33};
	localparam logic [32:0] HORNER_RECIP [HORNER_N] = '{
		33'(((64'd1 << 40) + 64'd131) / 64'd132),
		33'(((64'd1 << 39) + 64'd89) / 64'd90),
		33'(((64'd1 << 38) + 64'd55) / 64'd56),
		33'(((64'd1 << 37) + 64'd29) / 64'd30),
		33'(((64'd1 << 36) + 64'd11) / 64'd12),
		33'(((64'd1 << 33) + 64'd1) / 64'd2)
	};

	typedef enum logic {
		REG_EARTH_RADIUS = 1'b0
	} reg_index_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat_a;
		logic signed [LON_W-1:0] lon_a;
		logic signed [LAT_W-1:0] lat_b;
		logic signed [LON_W-1:0] lon_b;
	} pair_t;

	typedef struct packed {
		logic [28:0] dlon;
		logic [27:0] dlat;
	} diff_t;

	typedef struct packed {
		logic [31:0] x2;
		diff_t       dd;
	} horner_t;

	typedef struct packed {
		logic        sat;
		logic [55:0] qpi;
	} tail_t;

	typedef struct packed {
		logic [51:0] ll;
		logic [51:0] lh;
		logic [50:0] hl;
		logic [50:0] hh;
	} recip_pp_t;

	// partial products of n * TURN_RECIP in 26-bit limbs
	function automatic recip_pp_t recip_mul(input logic [50:0] n);
		recip_pp_t r;
		r.ll = 52'(n[25:0]) * 52'(TURN_RECIP[25:0]);
		r.lh = 52'(n[25:0]) * 52'(TURN_RECIP[51:26]);
		r.hl = 51'(n[50:26]) * 51'(TURN_RECIP[25:0]);
		r.hh = 51'(n[50:26]) * 51'(TURN_RECIP[51:26]);
		return r;
	endfunction

	// sum of the partial products, quotient bits
	function automatic logic [31:0] recip_quot(input recip_pp_t p);
		logic [103:0] s;
		s = (104'(p.hh) << 52) + (104'(p.lh) << 26) + (104'(p.hl) << 26) + 104'(p.ll);
		return s[RECIP_SH+31:RECIP_SH];
	endfunction

	// one digit of the square root, returns {remainder, root}
	function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
		input logic [1:0] pair);
		logic [35:0] t;
		logic [35:0] trial;
		logic [65:0] r;
		t = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (t >= trial) begin
			r = {34'(t - trial), root[30:0], 1'b1};
		end else begin
			r = {t[33:0], root[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hdl/eqgd_if.sv]
`timescale 1ns / 1ps
interface eqgd_pair_if;
	logic                              valid;
	logic                              ready;
	logic signed [eqgd_pkg::LAT_W-1:0] lat_a;
	logic signed [eqgd_pkg::LON_W-1:0] lon_a;
	logic signed [eqgd_pkg::LAT_W-1:0] lat_b;
	logic signed [eqgd_pkg::LON_W-1:0] lon_b;

	modport source(output valid, output lat_a, output lon_a, output lat_b, output lon_b,
		input ready);
	modport sink(input valid, input lat_a, input lon_a, input lat_b, input lon_b,
		output ready);
endinterface

interface eqgd_dist_if;
	logic                        valid;
	logic                        ready;
	logic [eqgd_pkg::DIST_W-1:0] distance;

	modport source(output valid, output distance, input ready);
	modport sink(input valid, input distance, output ready);
endinterface

[hdl/equirectangular_geo_distance.sv]
`timescale 1ns / 1ps
// channel   role    transfer when         payload
// pts       sink    valid & ready         lat_a, lon_a, lat_b, lon_b
// result    source  valid & ready         distance
// apb       slave   psel & penable        earth_radius at byte address 0
//
// one pair per cycle while the skid register is empty; the depth of the pipeline
// ahead of the output register is set mostly by the bit-serial stages of the square
// root and the two-stage reciprocal multiplications of the three divisions
// reset clears the pipeline, output and skid valid bits and presets the radius register
// a stalled result sits in the output register, the skid register takes one more,
// then the whole pipeline holds
module equirectangular_geo_distance (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [eqgd_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	eqgd_pair_if.sink                      pts,
	eqgd_dist_if.source                    result
);

	logic [eqgd_pkg::RADIUS_W-1:0] radius_q;
	eqgd_pkg::reg_index_t          reg_idx;
	logic                          en;
	logic                          dp_valid;
	logic [eqgd_pkg::DIST_W-1:0]   dp_dist;
	eqgd_pkg::pair_t               pair;
	logic                          out_valid_q;
	logic [eqgd_pkg::DIST_W-1:0]   out_dist_q;
	logic                          skid_valid_q;
	logic [eqgd_pkg::DIST_W-1:0]   skid_dist_q;

	assign pready  = 1'b1;
	assign reg_idx = eqgd_pkg::reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= eqgd_pkg::RADIUS_RESET;
		end else if (psel && penable && pwrite && reg_idx == eqgd_pkg::REG_EARTH_RADIUS) begin
			radius_q <= pwdata[eqgd_pkg::RADIUS_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			eqgd_pkg::REG_EARTH_RADIUS: prdata = 32'(radius_q);
			default:                    prdata = '0;
		endcase
	end

	assign en        = !skid_valid_q;
	assign pts.ready = en;
	assign pair      = '{lat_a: pts.lat_a, lon_a: pts.lon_a, lat_b: pts.lat_b,
		lon_b: pts.lon_b};

	eqgd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pts.valid),
		.pair      (pair),
		.radius    (radius_q),
		.out_valid (dp_valid),
		.distance  (dp_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= dp_valid;
			end
		end else if (dp_valid && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_dist_q <= skid_valid_q ? skid_dist_q : dp_dist;
		end else if (dp_valid && en) begin
			skid_dist_q <= dp_dist;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;

endmodule

[hdl/eqgd_datapath.sv]
`timescale 1ns / 1ps
module eqgd_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  eqgd_pkg::pair_t                 pair,
	input  logic [eqgd_pkg::RADIUS_W-1:0]   radius,
	output logic                            out_valid,
	output logic [eqgd_pkg::DIST_W-1:0]     distance
);

	localparam int SQ_W = eqgd_pkg::SQ_W;
	localparam int HN   = eqgd_pkg::HORNER_N;
	localparam int NSTG = eqgd_pkg::NSTG;

	logic valid_s [1:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	assign out_valid = valid_s[NSTG];

	// differences and twice the mean latitude
	logic signed [28:0] lat_sum;
	logic signed [29:0] lon_diff;
	logic signed [28:0] lat_diff;
	logic [28:0] sum_s1;
	eqgd_pkg::diff_t dd_s1, dd_s2, dd_s3, dd_s4;

	assign lat_sum  = 29'(pair.lat_a) + 29'(pair.lat_b);
	assign lon_diff = 30'(pair.lon_b) - 30'(pair.lon_a);
	assign lat_diff = 29'(pair.lat_b) - 29'(pair.lat_a);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= lat_sum[28] ? 29'(-lat_sum) : 29'(lat_sum);
			dd_s1.dlon <= lon_diff[29] ? 29'(-lon_diff) : 29'(lon_diff);
			dd_s1.dlat <= lat_diff[28] ? 28'(-lat_diff) : 28'(lat_diff);
		end
	end

	// angle reduction by the symmetries of |cos|
	logic [29:0] red_a, red_b;
	logic [28:0] r_s2;
	logic [27:0] r_s3;
	logic [50:0] n_s4;

	assign red_a = ({1'b0, sum_s1} >= eqgd_pkg::FULL_TURN) ?
		30'({1'b0, sum_s1} - eqgd_pkg::FULL_TURN) : {1'b0, sum_s1};
	assign red_b = (red_a > eqgd_pkg::HALF_TURN) ? 30'(eqgd_pkg::FULL_TURN - red_a) : red_a;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2  <= 29'(red_b);
			dd_s2 <= dd_s1;
			r_s3  <= ({1'b0, r_s2} > eqgd_pkg::QUARTER_TURN) ?
				28'(eqgd_pkg::HALF_TURN - {1'b0, r_s2}) : 28'(r_s2);
			dd_s3 <= dd_s2;
			n_s4  <= 51'((60'(r_s3) * 60'(eqgd_pkg::PI_Q30)) >> eqgd_pkg::HALF_SH);
			dd_s4 <= dd_s3;
		end
	end

	// angle in q30 radians: n / half turn
	eqgd_pkg::recip_pp_t xp_s5;
	eqgd_pkg::diff_t     dd_s5, dd_s6, dd_s7;
	logic [31:0]         x_s6;
	logic [31:0]         x2_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s5 <= eqgd_pkg::recip_mul(n_s4);
			dd_s5 <= dd_s4;
			x_s6  <= eqgd_pkg::recip_quot(xp_s5);
			dd_s6 <= dd_s5;
			x2_s7 <= 32'((64'(x_s6) * 64'(x_s6)) >> 30);
			dd_s7 <= dd_s6;
		end
	end

	// cosine series in horner form
	logic [31:0]       hm_s [HN];
	logic [64:0]       hp_s [HN];
	logic [30:0]       ht_s [HN];
	eqgd_pkg::horner_t hca_s [HN];
	eqgd_pkg::horner_t hcb_s [HN];
	eqgd_pkg::horner_t hcc_s [HN];

	for (genvar i = 0; i < HN; i++) begin : g_horner
		logic [30:0]       t_in;
		eqgd_pkg::horner_t c_in;
		logic [32:0]       qn;
		if (i == 0) begin : g_first
			assign t_in = eqgd_pkg::ONE_Q30;
			assign c_in = '{x2: x2_s7, dd: dd_s7};
		end else begin : g_next
			assign t_in = ht_s[i-1];
			assign c_in = hcc_s[i-1];
		end
		assign qn = 33'(hp_s[i] >> eqgd_pkg::HORNER_SH[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				hm_s[i]  <= 32'((64'(c_in.x2) * 64'(t_in)) >> 30);
				hca_s[i] <= c_in;
				hp_s[i]  <= 65'(hm_s[i]) * 65'(eqgd_pkg::HORNER_RECIP[i]);
				hcb_s[i] <= hca_s[i];
				ht_s[i]  <= (qn >= 33'(eqgd_pkg::ONE_Q30)) ? 31'd0 :
					31'(33'(eqgd_pkg::ONE_Q30) - qn);
				hcc_s[i] <= hcb_s[i];
			end
		end
	end

	// scaled terms and their squares
	logic [16:0] cos_q16;
	logic [30:0] u_s26;
	logic [29:0] v_s26;
	logic [61:0] uu_s27;
	logic [59:0] vv_s27;
	logic [62:0] sq_s28;

	assign cos_q16 = 17'(ht_s[HN-1] >> 14);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s26  <= 31'((46'(hcc_s[HN-1].dd.dlon) * 46'(cos_q16)) >> 14);
			v_s26  <= {hcc_s[HN-1].dd.dlat, 2'b00};
			uu_s27 <= 62'(u_s26) * 62'(u_s26);
			vv_s27 <= 60'(v_s26) * 60'(v_s26);
			sq_s28 <= 63'(uu_s27) + 63'(vv_s27);
		end
	end

	// integer square root, one bit a stage
	logic [33:0] sr_rem_s  [SQ_W];
	logic [31:0] sr_root_s [SQ_W];
	logic [63:0] sr_bits_s [SQ_W];

	for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
		logic [33:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] bits_in;
		logic [65:0] st;
		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign bits_in = {1'b0, sq_s28};
		end else begin : g_next
			assign rem_in  = sr_rem_s[j-1];
			assign root_in = sr_root_s[j-1];
			assign bits_in = sr_bits_s[j-1];
		end
		assign st = eqgd_pkg::sqrt_step(rem_in, root_in, bits_in[63:62]);
		always_ff @(posedge clk) begin
			if (en) begin
				sr_rem_s[j]  <= st[65:32];
				sr_root_s[j] <= st[31:0];
				sr_bits_s[j] <= {bits_in[61:0], 2'b00};
			end
		end
	end

	logic [55:0] p_s61;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s61 <= 56'(sr_root_s[SQ_W-1]) * 56'(radius);
		end
	end

	// h * radius / full turn, quotient and remainder
	eqgd_pkg::recip_pp_t qp_s62;
	logic [55:0]         p_s62, p_s63;
	logic [31:0]         q_s63;
	eqgd_pkg::tail_t     tl_s64, tl_s65, tl_s66, tl_s67;
	logic [29:0]         rem_s64;
	logic [49:0]         b_s65;

	always_ff @(posedge clk) begin
		if (en) begin
			qp_s62     <= eqgd_pkg::recip_mul(51'(p_s61[55:eqgd_pkg::FULL_SH]));
			p_s62      <= p_s61;
			q_s63      <= eqgd_pkg::recip_quot(qp_s62);
			p_s63      <= p_s62;
			tl_s64.sat <= (q_s63 > 32'(eqgd_pkg::DIST_MAX));
			tl_s64.qpi <= 56'(q_s63[eqgd_pkg::DIST_W-1:0]) * 56'(eqgd_pkg::PI_Q28);
			rem_s64    <= 30'(p_s63 - 56'(64'(q_s63) * 64'(eqgd_pkg::FULL_TURN)));
			tl_s65     <= tl_s64;
			b_s65      <= 50'((60'(rem_s64) * 60'(eqgd_pkg::PI_Q28)) >> eqgd_pkg::FULL_SH);
		end
	end

	// remainder * pi / full turn
	eqgd_pkg::recip_pp_t rp_s66;
	logic [31:0]         rq_s67;

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s66 <= eqgd_pkg::recip_mul(51'(b_s65));
			tl_s66 <= tl_s65;
			rq_s67 <= eqgd_pkg::recip_quot(rp_s66);
			tl_s67 <= tl_s66;
		end
	end

	logic [56:0] fsum;
	logic [28:0] fshift;
	logic [eqgd_pkg::DIST_W-1:0] dist_s68;

	assign fsum   = 57'(tl_s67.qpi) + 57'(rq_s67);
	assign fshift = 29'(fsum >> 28);

	always_ff @(posedge clk) begin
		if (en) begin
			if (tl_s67.sat || fshift > 29'(eqgd_pkg::DIST_MAX)) begin
				dist_s68 <= eqgd_pkg::DIST_MAX;
			end else begin
				dist_s68 <= fshift[eqgd_pkg::DIST_W-1:0];
			end
		end
	end

	assign distance = dist_s68;

endmodule
